// File: hdl/pbu_pkg.sv
// ----------------------------------------------------------------------------
// pbu_pkg
// Shared types and constants of the RGB pixel blend unit.
// ----------------------------------------------------------------------------
package pbu_pkg;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 8;
	localparam int unsigned GAIN_W    = 4;

	// Opcodes of the op field
	typedef enum logic [3:0] {
		OP_MULTIPLY  = 4'd0,
		OP_SUBTRACT  = 4'd1,
		OP_SCREEN    = 4'd2,
		OP_OVERLAY   = 4'd3,
		OP_ADD_GREEN = 4'd4,
		OP_SCALE_RED = 4'd5,
		OP_EXTRACT_R = 4'd6,
		OP_EXTRACT_G = 4'd7,
		OP_EXTRACT_B = 4'd8
	} op_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_OFFSET = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN     = 8'd1;

	localparam logic [CH_W-1:0]   GREEN_OFFSET_RST = 8'd200;
	localparam logic [GAIN_W-1:0] RED_GAIN_RST     = 4'd4;

	// Overlay picks the light branch when round(sum/3) >= 128, i.e. sum >= 383
	localparam logic [9:0] GREY_LIGHT_MIN = 10'd383;

	// Rounded-divide kinds handled by the per-channel datapath
	typedef enum logic [1:0] {
		BK_MULTIPLY = 2'd0,
		BK_SCREEN   = 2'd1,
		BK_OV_LIGHT = 2'd2,
		BK_OV_DARK  = 2'd3
	} blend_kind_t;

	// Load enables of the three pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} adv_t;

endpackage

// File: hdl/pbu_chan.sv
// ----------------------------------------------------------------------------
// pbu_chan
// One color channel of the two-layer blends: products, numerator, and a
// rounded divide by 255 with clamping. Two register stages plus an output tail.
// ----------------------------------------------------------------------------
module pbu_chan (
	input  logic                      clk,
	input  pbu_pkg::adv_t             adv,
	input  pbu_pkg::blend_kind_t      kind,
	input  logic [pbu_pkg::CH_W-1:0]  a,
	input  logic [pbu_pkg::CH_W-1:0]  b,
	output logic [pbu_pkg::CH_W-1:0]  res
);
	import pbu_pkg::*;

	logic [15:0]        prod_s1;
	logic [15:0]        inv_s1;
	blend_kind_t        kind_s1;

	logic signed [19:0] num;
	logic signed [19:0] t;
	logic               neg_s2;
	logic [16:0]        u_s2;

	logic [8:0]         qe;
	logic [9:0]         rem;
	logic [9:0]         q;

	// Stage 1: a*b and (255-a)*(255-b)
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			prod_s1 <= 16'(a) * 16'(b);
			inv_s1  <= 16'(8'd255 - a) * 16'(8'd255 - b);
			kind_s1 <= kind;
		end
	end

	// Numerator in units of 1/510, then +255 for half-up rounding
	always_comb begin
		case (kind_s1)
			BK_MULTIPLY: num = signed'({3'b000, prod_s1, 1'b0});
			BK_SCREEN:   num = signed'({3'b000, 16'(16'd65025 - inv_s1), 1'b0});
			BK_OV_LIGHT: num = 20'sd130050 - signed'({2'b00, inv_s1, 2'b00});
			BK_OV_DARK:  num = signed'({2'b00, prod_s1, 2'b00});
			default:     num = '0;
		endcase
		t = num + 20'sd255;
	end

	// Stage 2: sign and halved numerator
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			neg_s2 <= t[19];
			u_s2   <= t[17:1];
		end
	end

	// floor(u/255): estimate u>>8, then fix with the remainder (at most +2)
	always_comb begin
		qe  = u_s2[16:8];
		rem = {2'b00, u_s2[7:0]} + {1'b0, qe};
		if (rem >= 10'd510)
			q = {1'b0, qe} + 10'd2;
		else if (rem >= 10'd255)
			q = {1'b0, qe} + 10'd1;
		else
			q = {1'b0, qe};
		if (neg_s2)
			res = '0;
		else if (q > 10'd255)
			res = 8'd255;
		else
			res = q[7:0];
	end

endmodule

// File: hdl/rgb_pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// rgb_pixel_blend_unit
// Blends top and base RGB pixels by opcode, one pixel per clock if unstalled.
// ----------------------------------------------------------------------------
// Three-stage pipeline, one beat in and one beat out per clock when the
// output side keeps out_ready high; each beat passes the stage 1, 2 and 3
// registers. Stage 1 forms the 8x8 products of each channel (a*b and the
// inverted product), stage 2 builds the rounded numerator, stage 3 divides by
// 255 with a reciprocal estimate and small correction, clamps, and selects
// against the one-operand modes, which are settled in stage 1 and ride along.
// Backpressure stalls only stages that hold data, so bubbles are squeezed out
// and no beat is dropped or repeated. Configuration writes (green offset at
// index 0, red gain at index 1, other indexes ignored) are taken at any time
// with cfg_ready tied high; they should be made while the pipeline is empty.
// Unused opcodes produce a black pixel.
// ----------------------------------------------------------------------------
module rgb_pixel_blend_unit (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pbu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbu_pkg::CFG_DAT_W-1:0]  cfg_data,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [3:0]                     op,
	input  logic [pbu_pkg::CH_W-1:0]       top_red,
	input  logic [pbu_pkg::CH_W-1:0]       top_green,
	input  logic [pbu_pkg::CH_W-1:0]       top_blue,
	input  logic [pbu_pkg::CH_W-1:0]       base_red,
	input  logic [pbu_pkg::CH_W-1:0]       base_green,
	input  logic [pbu_pkg::CH_W-1:0]       base_blue,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pbu_pkg::CH_W-1:0]       out_red,
	output logic [pbu_pkg::CH_W-1:0]       out_green,
	output logic [pbu_pkg::CH_W-1:0]       out_blue
);
	import pbu_pkg::*;

	// configuration registers
	logic [CH_W-1:0]   green_offset_q;
	logic [GAIN_W-1:0] red_gain_q;

	adv_t              adv;
	logic              valid_s1, valid_s2, valid_s3;

	// decode
	op_t               op_in;
	blend_kind_t       kind;
	logic              use_blend;
	logic [9:0]        grey_sum;
	logic [8:0]        green_sum;
	logic [11:0]       red_scaled;
	logic [CH_W-1:0]   simp_r, simp_g, simp_b;

	logic              blend_s1, blend_s2;
	logic [CH_W-1:0]   simp_r_s1, simp_g_s1, simp_b_s1;
	logic [CH_W-1:0]   simp_r_s2, simp_g_s2, simp_b_s2;

	logic [CH_W-1:0]   res_r, res_g, res_b;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_offset_q <= GREEN_OFFSET_RST;
			red_gain_q     <= RED_GAIN_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_GREEN_OFFSET)
				green_offset_q <= cfg_data;
			if (cfg_index == REG_RED_GAIN)
				red_gain_q <= cfg_data[GAIN_W-1:0];
		end
	end

	// a stage loads when it is empty or its content moves on
	always_comb begin
		adv.s3 = !valid_s3 || out_ready;
		adv.s2 = !valid_s2 || adv.s3;
		adv.s1 = !valid_s1 || adv.s2;
	end

	assign in_ready  = adv.s1;
	assign out_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv.s1)
				valid_s1 <= in_valid;
			if (adv.s2)
				valid_s2 <= valid_s1;
			if (adv.s3)
				valid_s3 <= valid_s2;
		end
	end

	// opcode decode and the one-operand modes
	always_comb begin
		op_in      = op_t'(op);
		grey_sum   = {2'b00, base_red} + {2'b00, base_green} + {2'b00, base_blue};
		green_sum  = {1'b0, base_green} + {1'b0, green_offset_q};
		red_scaled = 12'(red_gain_q) * 12'(base_red);
		kind       = BK_MULTIPLY;
		use_blend  = 1'b0;
		simp_r     = '0;
		simp_g     = '0;
		simp_b     = '0;
		case (op_in)
			OP_MULTIPLY: begin
				use_blend = 1'b1;
				kind      = BK_MULTIPLY;
			end
			OP_SCREEN: begin
				use_blend = 1'b1;
				kind      = BK_SCREEN;
			end
			OP_OVERLAY: begin
				use_blend = 1'b1;
				kind      = (grey_sum >= GREY_LIGHT_MIN) ? BK_OV_LIGHT : BK_OV_DARK;
			end
			OP_SUBTRACT: begin
				simp_r = (base_red   > top_red)   ? base_red   - top_red   : '0;
				simp_g = (base_green > top_green) ? base_green - top_green : '0;
				simp_b = (base_blue  > top_blue)  ? base_blue  - top_blue  : '0;
			end
			OP_ADD_GREEN: begin
				simp_r = base_red;
				simp_g = green_sum[8] ? 8'd255 : green_sum[7:0];
				simp_b = base_blue;
			end
			OP_SCALE_RED: begin
				simp_r = (|red_scaled[11:8]) ? 8'd255 : red_scaled[7:0];
				simp_g = base_green;
			end
			OP_EXTRACT_R: begin
				simp_r = base_red;
				simp_g = base_red;
				simp_b = base_red;
			end
			OP_EXTRACT_G: begin
				simp_r = base_green;
				simp_g = base_green;
				simp_b = base_green;
			end
			OP_EXTRACT_B: begin
				simp_r = base_blue;
				simp_g = base_blue;
				simp_b = base_blue;
			end
			default: begin
				use_blend = 1'b0;
			end
		endcase
	end

	// side path for the one-operand result, kept in step with the channels
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			blend_s1  <= use_blend;
			simp_r_s1 <= simp_r;
			simp_g_s1 <= simp_g;
			simp_b_s1 <= simp_b;
		end
		if (adv.s2) begin
			blend_s2  <= blend_s1;
			simp_r_s2 <= simp_r_s1;
			simp_g_s2 <= simp_g_s1;
			simp_b_s2 <= simp_b_s1;
		end
	end

	pbu_chan u_chan_r (
		.clk  (clk),
		.adv  (adv),
		.kind (kind),
		.a    (top_red),
		.b    (base_red),
		.res  (res_r)
	);

	pbu_chan u_chan_g (
		.clk  (clk),
		.adv  (adv),
		.kind (kind),
		.a    (top_green),
		.b    (base_green),
		.res  (res_g)
	);

	pbu_chan u_chan_b (
		.clk  (clk),
		.adv  (adv),
		.kind (kind),
		.a    (top_blue),
		.b    (base_blue),
		.res  (res_b)
	);

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			out_red   <= blend_s2 ? res_r : simp_r_s2;
			out_green <= blend_s2 ? res_g : simp_g_s2;
			out_blue  <= blend_s2 ? res_b : simp_b_s2;
		end
	end

endmodule

// File: test/tb_rgb_pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// tb_rgb_pixel_blend_unit
// Self-checking bench for the RGB pixel blend unit.
// ----------------------------------------------------------------------------
// Every accepted input beat is run through a local pixel predictor that holds
// its own copy of the green offset and red gain. The prediction is queued and
// compared channel by channel with the next output beat. Stimulus is a short
// directed set (reset values, corners of every mode, overlay edge cases,
// unused opcodes), a register sweep, random phases with reprogramming between
// them, and a final stretch at full rate with no idling on either side.
// ----------------------------------------------------------------------------
module tb_rgb_pixel_blend_unit;
	import pbu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	// Indexes outside the register list, written to prove they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'd255;

	// Opcodes with no mode behind them
	localparam logic [3:0] OP_SPARE_LO = 4'd9;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [3:0]           op;
	logic [CH_W-1:0]      top_red;
	logic [CH_W-1:0]      top_green;
	logic [CH_W-1:0]      top_blue;
	logic [CH_W-1:0]      base_red;
	logic [CH_W-1:0]      base_green;
	logic [CH_W-1:0]      base_blue;
	logic                 out_valid;
	logic                 out_ready;
	logic [CH_W-1:0]      out_red;
	logic [CH_W-1:0]      out_green;
	logic [CH_W-1:0]      out_blue;

	// Shadow copy of the block's registers, updated on each config beat to one of them
	logic [CH_W-1:0]   shadow_green_offset = GREEN_OFFSET_RST;
	logic [GAIN_W-1:0] shadow_red_gain     = RED_GAIN_RST;

	pixel_t expected_pixels[$];
	pixel_t oldest_pixel;
	int     mismatch_count = 0;
	int     cycle_count = 0;
	bit     tx_idle = 1'b1;
	bit     rx_idle = 1'b1;
	int     rx_stall = 0;

	rgb_pixel_blend_unit i_dut (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ------------------------------------------------------------------
	// Pixel predictor
	// ------------------------------------------------------------------
	function automatic logic [CH_W-1:0] clamp_level(input int v);
		if (v < 0)
			return '0;
		if (v > 255)
			return 8'd255;
		return 8'(v);
	endfunction

	// One channel of the two-layer modes; a is the top, b the base channel
	function automatic logic [CH_W-1:0] blend_channel(input logic [3:0] code,
			input logic [CH_W-1:0] top_lvl, input logic [CH_W-1:0] base_lvl, input bit light);
		int a;
		int b;
		int n;
		int v;
		a = int'(top_lvl);
		b = int'(base_lvl);
		v = 0;
		case (code)
			OP_MULTIPLY: v = (2 * a * b + 255) / 510;
			OP_SUBTRACT: v = (b > a) ? b - a : 0;
			OP_SCREEN: begin
				n = 65025 - (255 - a) * (255 - b);
				v = (2 * n + 255) / 510;
			end
			OP_OVERLAY: begin
				if (light) begin
					// numerator may go negative; clamp before dividing
					n = 2 * (65025 - 2 * (255 - a) * (255 - b)) + 255;
					v = (n < 0) ? 0 : n / 510;
				end else begin
					v = (4 * a * b + 255) / 510;
				end
			end
			default: v = 0;
		endcase
		return clamp_level(v);
	endfunction

	function automatic pixel_t predict_pixel(input logic [3:0] code, input pixel_t top,
			input pixel_t base);
		pixel_t res;
		int     grey;
		bit     light;
		grey = (2 * (int'(base.red) + int'(base.green) + int'(base.blue)) + 3) / 6;
		light = (grey >= 128);
		res = '0;
		case (code)
			OP_MULTIPLY, OP_SUBTRACT, OP_SCREEN, OP_OVERLAY: begin
				res.red   = blend_channel(code, top.red, base.red, light);
				res.green = blend_channel(code, top.green, base.green, light);
				res.blue  = blend_channel(code, top.blue, base.blue, light);
			end
			OP_ADD_GREEN: begin
				res.red   = base.red;
				res.green = clamp_level(int'(base.green) + int'(shadow_green_offset));
				res.blue  = base.blue;
			end
			OP_SCALE_RED: begin
				res.red   = clamp_level(int'(shadow_red_gain) * int'(base.red));
				res.green = base.green;
				res.blue  = '0;
			end
			OP_EXTRACT_R: res = {3{base.red}};
			OP_EXTRACT_G: res = {3{base.green}};
			OP_EXTRACT_B: res = {3{base.blue}};
			default: res = '0;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: checks output beats, records input and config beats
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [CH_W-1:0] want,
			input logic [CH_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					mismatch_count++;
					$display("%0t: output beat, expected none, actual %0d %0d %0d",
						$time, out_red, out_green, out_blue);
				end else begin
					oldest_pixel = expected_pixels.pop_front();
					check_field("out_red", oldest_pixel.red, out_red);
					check_field("out_green", oldest_pixel.green, out_green);
					check_field("out_blue", oldest_pixel.blue, out_blue);
				end
			end
			if (in_valid && in_ready)
				expected_pixels = {expected_pixels, predict_pixel(op,
					{top_red, top_green, top_blue}, {base_red, base_green, base_blue})};
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GREEN_OFFSET)
					shadow_green_offset = cfg_data;
				else if (cfg_index == REG_RED_GAIN)
					shadow_red_gain = cfg_data[GAIN_W-1:0];
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Output side: out_ready drops in random bursts of stall cycles
	// ------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_stall > 0) begin
				out_ready = 1'b0;
				rx_stall--;
			end else if (rx_idle && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				rx_stall = $urandom_range(1, 17) - 1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// One input beat; an optional idle burst goes first, with junk on the
	// payload while valid is low.
	task automatic send_pixel(input logic [3:0] code, input pixel_t top, input pixel_t base);
		int gap;
		gap = 0;
		if (tx_idle && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 17);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			{op, top_red, top_green, top_blue} = {4'($urandom), 24'($urandom)};
			{base_red, base_green, base_blue} = 24'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		op         = code;
		top_red    = top.red;
		top_green  = top.green;
		top_blue   = top.blue;
		base_red   = base.red;
		base_green = base.green;
		base_blue  = base.blue;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and hold off until every queued result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_pixels.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Random content
	// ------------------------------------------------------------------
	// Channel level biased toward the ends and the mid-scale
	function automatic logic [CH_W-1:0] rand_level();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(125, 130));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		return {rand_level(), rand_level(), rand_level()};
	endfunction

	// Base pixel whose channel sum sits around the overlay light/dark split
	function automatic pixel_t near_grey_split();
		int sum;
		int d;
		sum = $urandom_range(376, 390);
		d = $urandom_range(0, 100);
		return {8'(sum / 3 + d), 8'(sum / 3 - d), 8'(sum - 2 * (sum / 3))};
	endfunction

	task automatic send_random_pixel();
		logic [3:0] code;
		pixel_t     base;
		if ($urandom_range(0, 19) < 18)
			code = 4'($urandom_range(0, 8));
		else
			code = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		if (code == OP_OVERLAY && $urandom_range(0, 2) == 0)
			base = near_grey_split();
		else
			base = rand_pixel();
		send_pixel(code, rand_pixel(), base);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Add and scale modes with the registers still at reset values
	task automatic test_register_reset();
		send_pixel(OP_ADD_GREEN, {8'd9, 8'd1, 8'd2}, {8'd10, 8'd0, 8'd20});
		send_pixel(OP_ADD_GREEN, {8'd0, 8'd0, 8'd0}, {8'd255, 8'd55, 8'd0});
		send_pixel(OP_ADD_GREEN, {8'd0, 8'd0, 8'd0}, {8'd0, 8'd56, 8'd255});
		send_pixel(OP_ADD_GREEN, {8'd255, 8'd255, 8'd255}, {8'd1, 8'd255, 8'd1});
		send_pixel(OP_SCALE_RED, {8'd0, 8'd0, 8'd0}, {8'd0, 8'd17, 8'd99});
		send_pixel(OP_SCALE_RED, {8'd0, 8'd0, 8'd0}, {8'd63, 8'd0, 8'd255});
		send_pixel(OP_SCALE_RED, {8'd0, 8'd0, 8'd0}, {8'd64, 8'd255, 8'd1});
		send_pixel(OP_SCALE_RED, {8'd255, 8'd255, 8'd255}, {8'd255, 8'd128, 8'd128});
	endtask

	// Corners of the two-layer modes, overlay edges, extract, unused opcodes
	task automatic test_blend_corners();
		send_pixel(OP_MULTIPLY, {8'd255, 8'd0, 8'd1}, {8'd255, 8'd255, 8'd128});
		send_pixel(OP_MULTIPLY, {8'd0, 8'd255, 8'd128}, {8'd0, 8'd255, 8'd127});
		send_pixel(OP_SUBTRACT, {8'd0, 8'd255, 8'd100}, {8'd255, 8'd0, 8'd100});
		send_pixel(OP_SCREEN, {8'd0, 8'd255, 8'd1}, {8'd0, 8'd0, 8'd254});
		send_pixel(OP_SCREEN, {8'd255, 8'd255, 8'd128}, {8'd255, 8'd0, 8'd127});
		// channel sum 382 rounds to grey 127: dark branch
		send_pixel(OP_OVERLAY, {8'd255, 8'd0, 8'd200}, {8'd127, 8'd127, 8'd128});
		// channel sum 383 rounds to grey 128: light branch
		send_pixel(OP_OVERLAY, {8'd0, 8'd255, 8'd60}, {8'd128, 8'd127, 8'd128});
		// light branch with a negative numerator on blue
		send_pixel(OP_OVERLAY, {8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd0});
		// dark branch overshooting 255 on red
		send_pixel(OP_OVERLAY, {8'd255, 8'd255, 8'd0}, {8'd255, 8'd0, 8'd0});
		send_pixel(OP_OVERLAY, {8'd255, 8'd255, 8'd255}, {8'd255, 8'd255, 8'd255});
		send_pixel(OP_OVERLAY, {8'd0, 8'd0, 8'd0}, {8'd0, 8'd0, 8'd0});
		send_pixel(OP_EXTRACT_R, {8'd255, 8'd255, 8'd255}, {8'd12, 8'd34, 8'd56});
		send_pixel(OP_EXTRACT_G, {8'd255, 8'd255, 8'd255}, {8'd12, 8'd34, 8'd56});
		send_pixel(OP_EXTRACT_B, {8'd255, 8'd255, 8'd255}, {8'd12, 8'd34, 8'd56});
		send_pixel(OP_SPARE_LO, {8'd255, 8'd255, 8'd255}, {8'd255, 8'd255, 8'd255});
		send_pixel(OP_SPARE_HI, {8'd255, 8'd255, 8'd255}, {8'd255, 8'd255, 8'd255});
		send_pixel(OP_ADD_GREEN, {8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255});
	endtask

	// Register extremes; gain data carries junk in the upper bits, and the
	// last setting is followed by writes to indexes that do not exist
	task automatic test_register_sweep();
		logic [CFG_DAT_W-1:0] offsets[4];
		logic [CFG_DAT_W-1:0] gains[4];
		pixel_t               base;
		offsets = '{8'd0, 8'd255, 8'd1, 8'd77};
		gains   = '{8'd0, 8'd15, 8'hF7, 8'hA9};
		for (int s = 0; s < 4; s++) begin
			write_reg(REG_GREEN_OFFSET, offsets[s]);
			write_reg(REG_RED_GAIN, gains[s]);
			if (s == 3) begin
				write_reg(REG_SPARE_LO, 8'h00);
				write_reg(REG_SPARE_HI, 8'hFF);
			end
			for (int i = 0; i < 20; i++) begin
				base = rand_pixel();
				case ($urandom_range(0, 2))
					0: send_pixel(OP_ADD_GREEN, rand_pixel(), base);
					1: send_pixel(OP_SCALE_RED, rand_pixel(), base);
					default: send_random_pixel();
				endcase
			end
		end
	endtask

	// Random phases, each starting from a drained pipe with new settings
	task automatic test_random_blends(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			write_reg(REG_GREEN_OFFSET, 8'($urandom));
			write_reg(REG_RED_GAIN, 8'($urandom));
			if ($urandom_range(0, 2) == 0)
				write_reg(8'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 8'($urandom));
			for (int i = 0; i < per_phase; i++)
				send_random_pixel();
		end
	endtask

	// Back-to-back beats with both sides always ready
	task automatic test_full_rate(input int count);
		tx_idle  = 1'b0;
		rx_idle  = 1'b0;
		rx_stall = 0;
		for (int i = 0; i < count; i++)
			send_random_pixel();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		op         = '0;
		top_red    = '0;
		top_green  = '0;
		top_blue   = '0;
		base_red   = '0;
		base_green = '0;
		base_blue  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_reset();
		test_blend_corners();
		test_register_sweep();
		test_random_blends(6, 190);
		wait_drained();
		test_full_rate(150);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_pixels.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
hdl/pbu_pkg.sv
hdl/pbu_chan.sv
hdl/rgb_pixel_blend_unit.sv
test/tb_rgb_pixel_blend_unit.sv
